/* sv/bh32_pkg.sv */
// bh32_pkg: shared types, constants and the mix round for the byte hash unit
// used by bh32_front, bh32_queue, bh32_back and byte_hash_32bit_mix_unit
// no dependencies
package bh32_pkg;

    localparam logic [31:0] GOLDEN_WORD   = 32'h9E3779B9;
    localparam logic [3:0]  BLOCK_END_POS = 4'd11;
    localparam logic [3:0]  MIX_LAST_ROW  = 4'd8;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // byte lanes of a block
    localparam logic [1:0] LANE_A = 2'd0;
    localparam logic [1:0] LANE_B = 2'd1;

    // one unit of work for the mixing side
    typedef struct packed {
        logic        start;      // first job of a message: load fresh state
        logic        full_mix;   // a complete block closes with this word
        logic        final_mix;  // message ends: add length, mix, emit c
        logic [31:0] seed;
        logic [31:0] a_bytes;
        logic [31:0] b_bytes;
        logic [31:0] c_bytes;
        logic [31:0] length;
    } t_job;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_words;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIX,
        BK_LEN,
        BK_OUT
    } t_back_state;

    // one row of the three-word mix: one word takes two subtracts and an xor
    function automatic t_words mix_row(input logic [3:0] row, input t_words w);
        t_words r;
        r = w;
        case (row)
            4'd0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
            4'd1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
            4'd2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
            4'd3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
            4'd4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
            4'd5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
            4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
            4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
            4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

/* sv/bh32_front.sv */
// bh32_front: takes message bytes, places them into block words and
// hands one job per complete block or message end to the queue; uses bh32_pkg
module bh32_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_byte_present,
    input  logic                 i_last,
    input  logic                 i_seed_we,
    input  logic [31:0]          i_seed_wdata,
    output logic                 o_push,
    output bh32_pkg::t_job       o_job,
    input  logic                 i_full
);

    logic        r_busy, n_busy;
    logic        r_job_sent, n_job_sent;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [31:0] r_acc_a, n_acc_a;
    logic [31:0] r_acc_b, n_acc_b;
    logic [23:0] r_tail, n_tail;
    logic [31:0] r_seed;
    logic [31:0] r_msg_seed, n_msg_seed;

    logic        w_active, w_start, w_done, w_sent;
    logic [3:0]  w_pos;
    logic [31:0] w_len, w_acc_a, w_acc_b, w_byte_w;
    logic [23:0] w_tail, w_tail_add;
    logic [4:0]  w_shift;

    assign o_ready = !i_full;

    always_comb begin
        w_active = i_valid && !i_full && (i_byte_present || i_last);
        w_start  = !r_busy;

        w_pos   = w_start ? 4'd0  : r_pos;
        w_len   = w_start ? 32'd0 : r_len;
        w_acc_a = w_start ? 32'd0 : r_acc_a;
        w_acc_b = w_start ? 32'd0 : r_acc_b;
        w_tail  = w_start ? 24'd0 : r_tail;
        w_sent  = w_start ? 1'b0  : r_job_sent;
        n_msg_seed = w_start ? r_seed : r_msg_seed;

        w_shift  = {w_pos[1:0], 3'b000};
        w_byte_w = 32'(i_data_byte) << w_shift;
        w_done   = i_byte_present && (w_pos == bh32_pkg::BLOCK_END_POS);

        // every byte position starts at zero, so placing a byte is an or
        n_acc_a = w_acc_a;
        n_acc_b = w_acc_b;
        n_tail  = w_tail;
        w_tail_add = w_byte_w[23:0];
        if (i_byte_present) begin
            case (w_pos[3:2])
                bh32_pkg::LANE_A: n_acc_a = w_acc_a | w_byte_w;
                bh32_pkg::LANE_B: n_acc_b = w_acc_b | w_byte_w;
                default: begin
                    if (!w_done) begin
                        n_tail = w_tail | w_tail_add;
                    end
                end
            endcase
        end
        n_len = w_len + 32'(i_byte_present);

        o_push          = w_active && (w_done || i_last);
        o_job.start     = !w_sent;
        o_job.full_mix  = w_done;
        o_job.final_mix = i_last;
        o_job.seed      = n_msg_seed;
        o_job.a_bytes   = n_acc_a;
        o_job.b_bytes   = n_acc_b;
        // a short final block shifts its c bytes up, leaving the low byte free
        o_job.c_bytes   = w_done ? {i_data_byte, w_tail} : {n_tail, 8'h00};
        o_job.length    = n_len;

        n_busy     = !i_last;
        n_job_sent = !i_last && (w_sent || w_done);
        n_pos      = w_done ? 4'd0 : (w_pos + 4'(i_byte_present));
        if (w_done) begin
            n_acc_a = 32'd0;
            n_acc_b = 32'd0;
            n_tail  = 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd0;
        end else if (i_seed_we) begin
            r_seed <= i_seed_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_job_sent <= 1'b0;
            r_pos      <= 4'd0;
            r_len      <= 32'd0;
        end else if (w_active) begin
            r_busy     <= n_busy;
            r_job_sent <= n_job_sent;
            r_pos      <= n_pos;
            r_len      <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_active) begin
            r_acc_a    <= n_acc_a;
            r_acc_b    <= n_acc_b;
            r_tail     <= n_tail;
            r_msg_seed <= n_msg_seed;
        end
    end

endmodule

/* sv/bh32_queue.sv */
// bh32_queue: short first-in first-out queue of jobs between front and back
// uses bh32_pkg
module bh32_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bh32_pkg::t_job       i_job,
    output logic                 o_full,
    input  logic                 i_pop,
    output bh32_pkg::t_job       o_job,
    output logic                 o_empty
);

    bh32_pkg::t_job r_mem [bh32_pkg::QUEUE_DEPTH];

    logic [bh32_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [bh32_pkg::QUEUE_AW:0]   r_count, n_count;
    logic                          w_push, w_pop;

    always_comb begin
        o_full  = (r_count == (bh32_pkg::QUEUE_AW + 1)'(bh32_pkg::QUEUE_DEPTH));
        o_empty = (r_count == '0);
        w_push  = i_push && !o_full;
        w_pop   = i_pop && !o_empty;
        o_job   = r_mem[r_rd_ptr];
        n_count = r_count + (bh32_pkg::QUEUE_AW + 1)'(w_push)
                          - (bh32_pkg::QUEUE_AW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* sv/bh32_back.sv */
// bh32_back: holds words a, b and c, folds in each job and runs the mix one
// row per cycle; owns the result register; uses bh32_pkg
module bh32_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bh32_pkg::t_job       i_job,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_hash_value
);

    bh32_pkg::t_back_state r_state, n_state;
    bh32_pkg::t_words      r_w, n_w, w_base, w_row;

    logic [3:0]  r_row, n_row;
    logic        r_second, n_second;
    logic        r_final, n_final;
    logic [31:0] r_len, n_len;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_hash, n_out_hash;
    logic [31:0] w_len_add;

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bh32_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_row      <= n_row;
        r_second   <= n_second;
        r_final    <= n_final;
        r_len      <= n_len;
        r_out_hash <= n_out_hash;
    end

    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_row       = r_row;
        n_second    = r_second;
        n_final     = r_final;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_ready;
        n_out_hash  = r_out_hash;
        o_pop       = 1'b0;

        w_base.a  = i_job.start ? bh32_pkg::GOLDEN_WORD : r_w.a;
        w_base.b  = i_job.start ? bh32_pkg::GOLDEN_WORD : r_w.b;
        w_base.c  = i_job.start ? i_job.seed : r_w.c;
        // length goes in with a short final block; after a full block it waits
        w_len_add = (i_job.final_mix && !i_job.full_mix) ? i_job.length : 32'd0;
        w_row     = bh32_pkg::mix_row(r_row, r_w);

        case (r_state)
            bh32_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_w.a    = w_base.a + i_job.a_bytes;
                    n_w.b    = w_base.b + i_job.b_bytes;
                    n_w.c    = w_base.c + i_job.c_bytes + w_len_add;
                    n_second = i_job.full_mix && i_job.final_mix;
                    n_final  = i_job.final_mix;
                    n_len    = i_job.length;
                    n_row    = 4'd0;
                    n_state  = bh32_pkg::BK_MIX;
                end
            end
            bh32_pkg::BK_MIX: begin
                n_w   = w_row;
                n_row = r_row + 4'd1;
                if (r_row == bh32_pkg::MIX_LAST_ROW) begin
                    if (r_second) begin
                        n_state = bh32_pkg::BK_LEN;
                    end else if (r_final) begin
                        n_state = bh32_pkg::BK_OUT;
                    end else begin
                        n_state = bh32_pkg::BK_IDLE;
                    end
                end
            end
            bh32_pkg::BK_LEN: begin
                n_w.c    = r_w.c + r_len;
                n_second = 1'b0;
                n_row    = 4'd0;
                n_state  = bh32_pkg::BK_MIX;
            end
            bh32_pkg::BK_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = r_w.c;
                    n_state     = bh32_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = bh32_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

/* sv/byte_hash_32bit_mix_unit.sv */
// byte_hash_32bit_mix_unit: streaming three-word 32-bit byte hash, top level
// built from bh32_front, bh32_queue and bh32_back; uses bh32_pkg
//
//   port group   direction  handshake          payload
//   input word   in         i_valid / o_ready  i_data_byte, i_byte_present, i_last
//   hash word    out        o_valid / i_ready  o_hash_value
//   seed write   in         i_seed_we          i_seed_wdata
//
// one byte is taken per cycle while the job queue has room
// the mixer folds each block in and runs 9 mix rows; a message ending on a block
// boundary adds the length and mixes again; each message end loads the result
// many very short messages in a row are therefore paced by the mixer
// reset is synchronous and active low; it empties the queue and drops the result
// a stalled result waits in its register while input keeps flowing into the queue
module byte_hash_32bit_mix_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_value,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_wdata
);

    bh32_pkg::t_job w_push_job, w_pop_job;
    logic           w_push, w_full, w_pop, w_empty;

    bh32_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .i_seed_we      (i_seed_we),
        .i_seed_wdata   (i_seed_wdata),
        .o_push         (w_push),
        .o_job          (w_push_job),
        .i_full         (w_full)
    );

    bh32_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    bh32_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_pop_job),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

endmodule

/* tb/byte_hash_32bit_mix_unit_tb.sv */
// byte_hash_32bit_mix_unit_tb: self-checking bench for the streaming 32-bit byte hash
// drives byte words and seed writes, predicts each message hash and checks o_hash_value
// depends on bh32_pkg and byte_hash_32bit_mix_unit
`timescale 1ns / 1ps

module byte_hash_32bit_mix_unit_tb;

    localparam int unsigned BLOCK_BYTES   = 12;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned SQUEEZE_LEN   = 300;
    localparam int unsigned PHASE_WORDS   = 135;

    // expected hashes of finished messages, kept in arrival order
    class hash_scoreboard;
        logic [31:0] seed_reg;
        logic [31:0] wa, wb, wc;
        logic [31:0] tail_bytes;
        logic [31:0] msg_len;
        logic [3:0]  pos;
        bit          in_msg;
        logic [31:0] hash_q[$];
        int unsigned fails;

        function new();
            seed_reg = '0;
            in_msg   = 1'b0;
            fails    = 0;
        endfunction

        function void set_seed(input logic [31:0] v);
            seed_reg = v;
        endfunction

        function void churn();
            wa = (wa - wb - wc) ^ (wc >> 13);
            wb = (wb - wc - wa) ^ (wa << 8);
            wc = (wc - wa - wb) ^ (wb >> 13);
            wa = (wa - wb - wc) ^ (wc >> 12);
            wb = (wb - wc - wa) ^ (wa << 16);
            wc = (wc - wa - wb) ^ (wb >> 5);
            wa = (wa - wb - wc) ^ (wc >> 3);
            wb = (wb - wc - wa) ^ (wa << 10);
            wc = (wc - wa - wb) ^ (wb >> 15);
        endfunction

        function void note_word(input logic [7:0] d, input logic p, input logic l);
            logic [31:0] lane_val;
            if (!p && !l) return;
            if (!in_msg) begin
                wa         = bh32_pkg::GOLDEN_WORD;
                wb         = bh32_pkg::GOLDEN_WORD;
                wc         = seed_reg;
                pos        = '0;
                msg_len    = '0;
                tail_bytes = '0;
                in_msg     = 1'b1;
            end
            if (p) begin
                lane_val = {24'd0, d} << {pos[1:0], 3'b000};
                case (pos[3:2])
                    bh32_pkg::LANE_A: wa = wa + lane_val;
                    bh32_pkg::LANE_B: wb = wb + lane_val;
                    default: tail_bytes = tail_bytes + lane_val;
                endcase
                msg_len = msg_len + 32'd1;
                pos     = pos + 4'd1;
                if (pos == BLOCK_BYTES) begin
                    wc         = wc + tail_bytes;
                    tail_bytes = '0;
                    churn();
                    pos        = '0;
                end
            end
            if (l) begin
                // low byte of c is left for the length in a short block
                wc = wc + msg_len;
                wc = wc + (tail_bytes << 8);
                churn();
                hash_q.push_back(wc);
                in_msg     = 1'b0;
                pos        = '0;
                tail_bytes = '0;
            end
        endfunction

        function void check_hash(input logic [31:0] got);
            logic [31:0] want;
            if (hash_q.size() == 0) begin
                $error("hash_value: no word expected, actual %08h", got);
                fails++;
                return;
            end
            want = hash_q.pop_front();
            if (got !== want) begin
                $error("hash_value: expected %08h, actual %08h", want, got);
                fails++;
            end
        endfunction

        function int pending();
            return hash_q.size();
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_data_byte    = '0;
    logic        i_byte_present = 1'b0;
    logic        i_last         = 1'b0;
    logic        i_ready        = 1'b0;
    logic        i_seed_we      = 1'b0;
    logic [31:0] i_seed_wdata   = '0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_hash_value;

    hash_scoreboard sb;
    int unsigned    src_idle_pct  = 0;
    int unsigned    sink_idle_pct = 0;
    bit             squeeze_req   = 1'b0;
    int unsigned    squeeze_left  = 0;

    byte_hash_32bit_mix_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hash_value   (o_hash_value),
        .i_seed_we      (i_seed_we),
        .i_seed_wdata   (i_seed_wdata)
    );

    always #2 i_clk = ~i_clk;

    // result side: check accepted words, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            sb.check_hash(o_hash_value);
        end
        if (squeeze_left > 0) begin
            squeeze_left = squeeze_left - 1;
            i_ready <= 1'b0;
        end else if (squeeze_req) begin
            // long hold-off so the queue fills and the input stalls
            squeeze_req  = 1'b0;
            squeeze_left = SQUEEZE_LEN;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // each task starts and ends just after a rising edge
    task automatic put_word(input logic [7:0] d, input logic p, input logic l);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= d;
        i_byte_present <= p;
        i_last         <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(d, p, l);
    endtask

    task automatic write_seed(input logic [31:0] v);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= v;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
        sb.set_seed(v);
    endtask

    // wait for every hash, then let any result-less work leave the mixer
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_messages(input int unsigned budget);
        int unsigned sent;
        int unsigned len;
        bit          by_marker;
        sent = 0;
        while (sent < budget) begin
            len       = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(25);
            by_marker = (len == 0) || ($urandom_range(3) == 0);
            for (int unsigned k = 0; k < len; k++) begin
                if ($urandom_range(9) == 0) put_word(8'($urandom_range(255)), 1'b0, 1'b0);
                put_word(8'($urandom_range(255)), 1'b1, (k == len - 1) && !by_marker);
                sent++;
            end
            if (by_marker) begin
                put_word(8'($urandom_range(255)), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_seed(32'h0000_0000);
        put_word(8'h00, 1'b0, 1'b1);  // empty message
        put_word(8'hA5, 1'b0, 1'b0);  // no byte, no end: ignored
        put_word(8'hFF, 1'b1, 1'b1);
        put_word(8'h00, 1'b1, 1'b1);
        // one full block, ends on the block boundary
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            put_word({k[3:0], ~k[3:0]} ^ ((k % 3 == 0) ? 8'hFF : 8'h00), 1'b1,
                     k == BLOCK_BYTES - 1);
        end
        // bytes with an idle word inside, closed by an empty end marker
        put_word(8'h80, 1'b1, 1'b0);
        put_word(8'h3C, 1'b0, 1'b0);
        put_word(8'h7F, 1'b1, 1'b0);
        put_word(8'h01, 1'b1, 1'b0);
        put_word(8'h00, 1'b0, 1'b1);
        // seed change while a message is open only affects the next one
        put_word(8'hC3, 1'b1, 1'b0);
        put_word(8'h5A, 1'b1, 1'b0);
        drain();
        write_seed(32'hFFFF_FFFF);
        put_word(8'hE7, 1'b1, 1'b1);

        src_idle_pct  = 25;
        sink_idle_pct = 77;
        random_messages(PHASE_WORDS);
        drain();

        write_seed($urandom);
        src_idle_pct  = 77;
        sink_idle_pct = 25;
        random_messages(PHASE_WORDS);
        drain();

        write_seed($urandom);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        squeeze_req   = 1'b1;
        random_messages(PHASE_WORDS);
        drain();

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
